[src/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and helpers for the CPU affinity allocator
// Command, kind and status codes, the item passed between stages, and the
// mask helpers (lowest set bit, population count).
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MASK_W = 64;
  localparam int CPU_W  = 6;
  localparam int CNT_W  = 7;
  localparam int GEN_W  = 16;
  localparam logic [GEN_W-1:0] GEN_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC_IRQ  = 2'd0,
    CMD_REL_IRQ    = 2'd1,
    CMD_ALLOC_PROC = 2'd2,
    CMD_REL_PROC   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SDMA    = 2'd0,
    KIND_RCV     = 2'd1,
    KIND_GENERAL = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOCPU    = 3'd2,
    ST_PRESET   = 3'd3,
    ST_RELEASED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_DEFAULT_POOL = 2'd0,
    REG_RCV_POOL     = 2'd1,
    REG_PROC_POOL    = 2'd2,
    REG_DEV_NODE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    cmd_t              cmd;
    kind_t             kind;
    logic              ctrl;
    logic [CPU_W-1:0]  rel;
    logic [MASK_W-1:0] allowed;
    logic [MASK_W-1:0] req_node;
    logic              node_given;
    logic [CNT_W-1:0]  allowed_cnt;
  } item_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    status_t          status;
  } result_t;

  // Lowest set bit; zero for an empty mask.
  function automatic logic [CPU_W-1:0] lowest_cpu(input logic [MASK_W-1:0] m);
    logic [CPU_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) idx = CPU_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [CNT_W-1:0] count_cpus(input logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + CNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

[src/cpa_in_stage.sv]
// ----------------------------------------------------------------------------
// cpa_in_stage: input register
// Captures one request word per cycle unless stalled and counts the allowed CPUs on entry.
// ----------------------------------------------------------------------------
module cpa_in_stage import cpa_pkg::*; #(
  parameter int CPU_COUNT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [3:0]   in_tuser,
  input  logic         advance,
  output logic         item_valid,
  output item_t        item
);

  localparam logic [MASK_W-1:0] ALL = {MASK_W{1'b1}} >> (MASK_W - CPU_COUNT);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    item_nxt             = item_r;
    item_nxt.cmd         = cmd_t'(in_tuser[1:0]);
    item_nxt.kind        = kind_t'(in_tuser[3:2]);
    item_nxt.ctrl        = in_tdata[0];
    item_nxt.rel         = in_tdata[6:1];
    item_nxt.allowed     = in_tdata[70:7] & ALL;
    item_nxt.req_node    = in_tdata[134:71];
    item_nxt.node_given  = in_tdata[135];
    item_nxt.allowed_cnt = count_cpus(in_tdata[70:7] & ALL);
    valid_nxt            = take ? 1'b1 : (advance ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[src/cpa_core.sv]
// ----------------------------------------------------------------------------
// cpa_core: pool state and allocation decision
// Holds the used bitmaps and generation counts of the three pools and
// decides one request per cycle unless stalled; state advances when the request leaves.
// ----------------------------------------------------------------------------
module cpa_core import cpa_pkg::*; #(
  parameter int CPU_COUNT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  item_t            item,
  input  logic [MASK_W-1:0] dpool,
  input  logic [MASK_W-1:0] rpool,
  input  logic [MASK_W-1:0] ppool,
  input  logic [MASK_W-1:0] dev_node,
  input  logic [CNT_W-1:0]  ppool_cnt,
  output result_t          res
);

  localparam logic [MASK_W-1:0] ALL = {MASK_W{1'b1}} >> (MASK_W - CPU_COUNT);

  logic [MASK_W-1:0] d_used_r, d_used_nxt, r_used_r, r_used_nxt, p_used_r, p_used_nxt;
  logic [GEN_W-1:0]  d_gen_r, d_gen_nxt, r_gen_r, r_gen_nxt, p_gen_r, p_gen_nxt;

  logic [MASK_W-1:0] dmask, rmask, pmask, node, rel_bit;

  // interrupt pool picked by the request
  logic              sel_rx;
  logic [MASK_W-1:0] pu, pm, pu_rel, pu_base, pfree;
  logic [GEN_W-1:0]  pg, pg_rel, pg_up;
  logic              pu_full;
  logic [CPU_W-1:0]  pcpu, ctrl_cpu;

  // process pool
  logic [MASK_W-1:0] pr_rel, pr_base, intrs, freeset, cand1, quiet, cand2, cand;
  logic [GEN_W-1:0]  prg_rel, prg_up;
  logic              pr_full;
  logic [CPU_W-1:0]  ccpu;

  assign dmask   = dpool & ALL;
  assign rmask   = rpool & ALL;
  assign pmask   = ppool & ALL;
  assign node    = (item.node_given ? item.req_node : dev_node) & ALL;
  assign rel_bit = MASK_W'(1) << item.rel;

  assign sel_rx  = (item.kind == KIND_RCV) && ((item.cmd == CMD_REL_IRQ) || !item.ctrl);
  assign pu      = sel_rx ? r_used_r : d_used_r;
  assign pg      = sel_rx ? r_gen_r : d_gen_r;
  assign pm      = sel_rx ? rmask : dmask;
  assign pu_rel  = pu & ~rel_bit & ALL;
  assign pg_rel  = (pu_rel == '0 && pg != '0) ? pg - 1'b1 : pg;
  assign pu_full = (pu & ALL) == pm;
  assign pg_up   = (pu_full && pg != GEN_MAX) ? pg + 1'b1 : pg;
  assign pu_base = pu_full ? '0 : pu;
  assign pfree   = pm & ~pu_base;
  assign pcpu    = lowest_cpu(pfree);
  assign ctrl_cpu = lowest_cpu(dmask);

  assign pr_rel  = p_used_r & ~rel_bit & ALL;
  assign prg_rel = (pr_rel == '0 && p_gen_r != '0) ? p_gen_r - 1'b1 : p_gen_r;
  assign pr_full = (p_used_r & ALL) == pmask;
  assign prg_up  = (pr_full && p_gen_r != GEN_MAX) ? p_gen_r + 1'b1 : p_gen_r;
  assign pr_base = pr_full ? '0 : p_used_r;
  assign intrs   = ((d_gen_r != '0) ? dmask : (d_used_r & ALL)) |
                   ((r_gen_r != '0) ? rmask : (r_used_r & ALL));
  assign freeset = pmask & ~pr_base;
  assign cand1   = freeset & node;
  assign quiet   = cand1 & ~intrs;
  assign cand2   = (quiet != '0) ? quiet : cand1;
  assign cand    = (cand2 == '0) ? (freeset & ~node) : cand2;
  assign ccpu    = lowest_cpu(cand);

  always_comb begin
    d_used_nxt = d_used_r;
    r_used_nxt = r_used_r;
    p_used_nxt = p_used_r;
    d_gen_nxt  = d_gen_r;
    r_gen_nxt  = r_gen_r;
    p_gen_nxt  = p_gen_r;
    res.cpu    = '0;
    res.status = ST_OK;
    case (item.cmd)
      CMD_ALLOC_IRQ, CMD_REL_IRQ: begin
        if (item.kind == KIND_OTHER) begin
          res.status = ST_INVALID;
        end else if (item.cmd == CMD_REL_IRQ) begin
          res.status = ST_RELEASED;
          if (sel_rx) begin
            r_used_nxt = pu_rel;
            r_gen_nxt  = pg_rel;
          end else begin
            d_used_nxt = pu_rel;
            d_gen_nxt  = pg_rel;
          end
        end else if (item.kind == KIND_RCV && item.ctrl) begin
          // control context: first default CPU, no full-pool check
          if (dmask == '0) begin
            res.status = ST_NOCPU;
          end else begin
            res.cpu    = ctrl_cpu;
            d_used_nxt = d_used_r | (MASK_W'(1) << ctrl_cpu);
          end
        end else begin
          if (pfree == '0) begin
            res.status = ST_NOCPU;
          end else begin
            res.cpu = pcpu;
          end
          if (sel_rx) begin
            r_gen_nxt  = pg_up;
            r_used_nxt = (pfree == '0) ? pu_base : (pu_base | (MASK_W'(1) << pcpu));
          end else begin
            d_gen_nxt  = pg_up;
            d_used_nxt = (pfree == '0) ? pu_base : (pu_base | (MASK_W'(1) << pcpu));
          end
        end
      end
      CMD_REL_PROC: begin
        res.status = ST_RELEASED;
        p_used_nxt = pr_rel;
        p_gen_nxt  = prg_rel;
      end
      CMD_ALLOC_PROC: begin
        if (item.allowed_cnt == CNT_W'(1)) begin
          res.cpu    = lowest_cpu(item.allowed);
          res.status = ST_PRESET;
          p_used_nxt = p_used_r | item.allowed;
        end else if (item.allowed_cnt < ppool_cnt) begin
          res.status = ST_NOCPU;
        end else begin
          p_gen_nxt = prg_up;
          if (cand == '0) begin
            res.status = ST_NOCPU;
            p_used_nxt = pr_base;
          end else begin
            res.cpu    = ccpu;
            p_used_nxt = pr_base | (MASK_W'(1) << ccpu);
          end
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_used_r <= '0;
      r_used_r <= '0;
      p_used_r <= '0;
      d_gen_r  <= '0;
      r_gen_r  <= '0;
      p_gen_r  <= '0;
    end else if (fire) begin
      d_used_r <= d_used_nxt;
      r_used_r <= r_used_nxt;
      p_used_r <= p_used_nxt;
      d_gen_r  <= d_gen_nxt;
      r_gen_r  <= r_gen_nxt;
      p_gen_r  <= p_gen_nxt;
    end
  end

endmodule

[src/cpu_affinity_allocator.sv]
// ----------------------------------------------------------------------------
// cpu_affinity_allocator: CPU pool allocator for interrupts and processes
// Hands out CPU numbers from the default, receive and process pools, with
// used bitmaps, generation counts and node-aware process placement.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ------------------------------------
//  in_      in   in_tvalid/in_tready  request word (tdata 136b, tuser 4b)
//  out_     out  out_tvalid/tready    result word (tdata 8b, tuser 3b)
//  cfg_     in   cfg_wr_en            pool / node masks, 64b each
//
//  One request word per cycle while the output is not stalled. A word is
//  held in the input register, is decided by the pool logic and lands in
//  the output register, where its result is offered; throughput is one
//  word per cycle unless the output stalls, set by the single decision
//  stage that reads and updates pool state.
//  Reset clears pool state, masks and both valid flags.
//  A stalled output holds its word; the input register keeps taking a word
//  as long as the stage ahead of it moves.
//
module cpu_affinity_allocator import cpa_pkg::*; #(
  parameter int CPU_COUNT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // request
  input  logic         in_tvalid,
  output logic         in_tready,
  // is_control_context[0], cpu_index[6:1], allowed_mask[70:7],
  // requested_node_mask[134:71], node_given[135]
  input  logic [135:0] in_tdata,
  // cmd[1:0], irq_kind[3:2]
  input  logic [3:0]   in_tuser,
  // result
  output logic         out_tvalid,
  input  logic         out_tready,
  // chosen_cpu[5:0], zero pad[7:6]
  output logic [7:0]   out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wr_data
);

  localparam logic [MASK_W-1:0] ALL = {MASK_W{1'b1}} >> (MASK_W - CPU_COUNT);

  // configuration registers
  logic [MASK_W-1:0] dpool_r, rpool_r, ppool_r, dev_node_r;
  logic [CNT_W-1:0]  ppool_cnt_r;

  logic    item_valid, advance;
  item_t   item;
  result_t res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  // advance the decided word whenever the output slot is free or draining
  assign advance = item_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpool_r     <= '0;
      rpool_r     <= '0;
      ppool_r     <= '0;
      dev_node_r  <= '0;
      ppool_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_DEFAULT_POOL: dpool_r    <= cfg_wr_data;
        REG_RCV_POOL:     rpool_r    <= cfg_wr_data;
        REG_PROC_POOL: begin
          ppool_r     <= cfg_wr_data;
          // hold the pool size so the decline test needs no counter per word
          ppool_cnt_r <= count_cpus(cfg_wr_data & ALL);
        end
        REG_DEV_NODE:     dev_node_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  cpa_in_stage #(
    .CPU_COUNT (CPU_COUNT)
  ) u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cpa_core #(
    .CPU_COUNT (CPU_COUNT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item),
    .dpool     (dpool_r),
    .rpool     (rpool_r),
    .ppool     (ppool_r),
    .dev_node  (dev_node_r),
    .ppool_cnt (ppool_cnt_r),
    .res       (res)
  );

  // output register: load on advance, drop once taken
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.cpu};
  assign out_tuser  = out_r.status;

endmodule

[bench/tb_cpu_affinity_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu_affinity_allocator: self-checking bench for the CPU affinity allocator
// Streams request words into the allocator and keeps a request-level model of
// its three pools (used maps, generation counts, node-aware process
// placement). Every result word is checked in order against that model.
// Directed and empty-candidate cases come first, then output back-pressure,
// random traffic under several pool settings, and generation counter steps.
// ----------------------------------------------------------------------------
module tb_cpu_affinity_allocator;
  import cpa_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int LATENCY_SLACK = 8;
  localparam int IDLE_MAX      = 16;
  localparam int LONG_HOLD     = 200;
  localparam int PHASE_WORDS   = 250;
  localparam int GEN_WORDS     = 60;

  // Pool slots of the model; they line up with the register indexes.
  localparam int POOL_DFLT = 0;
  localparam int POOL_RCV  = 1;
  localparam int POOL_PROC = 2;

  typedef enum int {SET_SPARSE, SET_FULL, SET_EMPTY, SET_HIGH} pool_setting_t;

  typedef struct {
    cmd_t              cmd;
    kind_t             kind;
    logic              ctrl;
    logic [CPU_W-1:0]  rel;
    logic [MASK_W-1:0] allowed;
    logic [MASK_W-1:0] req_node;
    logic              node_given;
  } request_t;

  typedef struct {
    logic [CPU_W-1:0] cpu;
    status_t          status;
  } outcome_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [3:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_wr_data;

  // Model state: configured masks, used maps and generation counts.
  logic [MASK_W-1:0] pool_mask [3];
  logic [MASK_W-1:0] dev_node;
  logic [MASK_W-1:0] busy_map [3];
  logic [GEN_W-1:0]  gen_count [3];

  outcome_t pending_results [$];
  int       error_count   = 0;
  int       cycle_count   = 0;
  int       send_idle_max = 0;
  int       stall_max     = 0;
  int       stall_left    = 0;
  bit       hold_request  = 1'b0;

  cpu_affinity_allocator #(.CPU_COUNT(64)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case the allocator hangs on either handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_cpu_affinity_allocator failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Model of the allocator
  // ---------------------------------------------------------------------------
  function automatic logic [CPU_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
    for (int i = 0; i < MASK_W; i++) begin
      if (m[i]) return CPU_W'(i);
    end
    return '0;
  endfunction

  // Clear one used bit; an emptied pool steps its generation back (not below 0).
  function automatic void release_from_pool(input int p, input logic [CPU_W-1:0] c);
    busy_map[p][c] = 1'b0;
    if (busy_map[p] == '0 && gen_count[p] != '0) gen_count[p]--;
  endfunction

  // Interrupt allocation: a full pool starts a new generation, then take the
  // lowest free CPU.
  function automatic outcome_t take_from_pool(input int p);
    outcome_t          o;
    logic [MASK_W-1:0] free_set;
    o.cpu    = '0;
    o.status = ST_OK;
    if (busy_map[p] == pool_mask[p]) begin
      if (gen_count[p] != GEN_MAX) gen_count[p]++;
      busy_map[p] = '0;
    end
    free_set = pool_mask[p] & ~busy_map[p];
    if (free_set == '0) begin
      o.status = ST_NOCPU;
    end else begin
      o.cpu = lowest_set(free_set);
      busy_map[p][o.cpu] = 1'b1;
    end
    return o;
  endfunction

  function automatic outcome_t place_request(input request_t r);
    outcome_t          o;
    logic [MASK_W-1:0] node, intr_busy, free_set, cand, quiet;
    int                width;
    o.cpu    = '0;
    o.status = ST_OK;
    node     = r.node_given ? r.req_node : dev_node;
    case (r.cmd)
      CMD_ALLOC_IRQ, CMD_REL_IRQ: begin
        if (r.kind == KIND_OTHER) begin
          o.status = ST_INVALID;
        end else if (r.cmd == CMD_REL_IRQ) begin
          // receive kind always releases into the receive pool
          release_from_pool((r.kind == KIND_RCV) ? POOL_RCV : POOL_DFLT, r.rel);
          o.status = ST_RELEASED;
        end else if (r.kind == KIND_RCV && r.ctrl) begin
          // control context: first default CPU, no full-pool check
          if (pool_mask[POOL_DFLT] == '0) begin
            o.status = ST_NOCPU;
          end else begin
            o.cpu = lowest_set(pool_mask[POOL_DFLT]);
            busy_map[POOL_DFLT][o.cpu] = 1'b1;
          end
        end else begin
          o = take_from_pool((r.kind == KIND_RCV) ? POOL_RCV : POOL_DFLT);
        end
      end
      CMD_REL_PROC: begin
        release_from_pool(POOL_PROC, r.rel);
        o.status = ST_RELEASED;
      end
      default: begin
        width = $countones(r.allowed);
        if (width == 1) begin
          o.cpu = lowest_set(r.allowed);
          busy_map[POOL_PROC][o.cpu] = 1'b1;
          o.status = ST_PRESET;
        end else if (width < $countones(pool_mask[POOL_PROC])) begin
          o.status = ST_NOCPU;
        end else begin
          if (busy_map[POOL_PROC] == pool_mask[POOL_PROC]) begin
            if (gen_count[POOL_PROC] != GEN_MAX) gen_count[POOL_PROC]++;
            busy_map[POOL_PROC] = '0;
          end
          // a pool past its first generation counts as fully used by interrupts
          intr_busy = ((gen_count[POOL_DFLT] != '0) ? pool_mask[POOL_DFLT]
                                                    : busy_map[POOL_DFLT]) |
                      ((gen_count[POOL_RCV] != '0) ? pool_mask[POOL_RCV]
                                                   : busy_map[POOL_RCV]);
          free_set = pool_mask[POOL_PROC] & ~busy_map[POOL_PROC];
          cand     = free_set & node;
          quiet    = cand & ~intr_busy;
          if (quiet != '0) cand = quiet;
          if (cand == '0) cand = free_set & ~node;
          if (cand == '0) begin
            o.status = ST_NOCPU;
          end else begin
            o.cpu = lowest_set(cand);
            busy_map[POOL_PROC][o.cpu] = 1'b1;
          end
        end
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and in-order check
  // ---------------------------------------------------------------------------
  // Count down the current stall at each falling edge; a hold request replaces
  // it with one long stretch of back-pressure.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left   = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected: cpu %0d status %0d",
                 $time, out_tdata[CPU_W-1:0], out_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[CPU_W-1:0] !== want.cpu) begin
          $display("%0t: chosen_cpu mismatch, expected %0d, got %0d",
                   $time, want.cpu, out_tdata[CPU_W-1:0]);
          error_count++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_tuser);
          error_count++;
        end
      end
      stall_left = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one word after a random gap; valid stays high across back-to-back
  // words so it never gets two updates in one step.
  task automatic send_request(input request_t r);
    int gap;
    gap = (send_idle_max > 0) ? $urandom_range(0, send_idle_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.node_given, r.req_node, r.allowed, r.rel, r.ctrl};
    in_tuser  <= {r.kind, r.cmd};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(place_request(r));
  endtask

  // Drop valid and wait until every expected word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    case (idx)
      REG_DEFAULT_POOL: pool_mask[POOL_DFLT] = value;
      REG_RCV_POOL:     pool_mask[POOL_RCV]  = value;
      REG_PROC_POOL:    pool_mask[POOL_PROC] = value;
      default:          dev_node             = value;
    endcase
  endtask

  task automatic configure_pools(input logic [63:0] dflt, input logic [63:0] rcv,
                                 input logic [63:0] proc, input logic [63:0] node);
    write_register(REG_DEFAULT_POOL, dflt);
    write_register(REG_RCV_POOL, rcv);
    write_register(REG_PROC_POOL, proc);
    write_register(REG_DEV_NODE, node);
  endtask

  function automatic request_t build_request(input cmd_t cmd, input kind_t kind,
                                             input logic ctrl, input logic [5:0] rel,
                                             input logic [63:0] allowed,
                                             input logic [63:0] req_node,
                                             input logic node_given);
    request_t r;
    r.cmd        = cmd;
    r.kind       = kind;
    r.ctrl       = ctrl;
    r.rel        = rel;
    r.allowed    = allowed;
    r.req_node   = req_node;
    r.node_given = node_given;
    return r;
  endfunction

  function automatic logic [63:0] sparse_mask(input int lo_n, input int hi_n);
    logic [63:0] m;
    m = '0;
    repeat ($urandom_range(lo_n, hi_n)) m[$urandom_range(0, 63)] = 1'b1;
    return m;
  endfunction

  function automatic logic [63:0] random_mask();
    logic [63:0] m;
    case ($urandom_range(0, 7))
      0:       m = '0;
      1:       m = '1;
      2:       m = 64'd1 << $urandom_range(0, 63);
      3, 4:    m = sparse_mask(2, 6);
      default: m = {$urandom(), $urandom()};
    endcase
    return m;
  endfunction

  // Mostly well-formed traffic: releases aim at CPUs in use, process requests
  // mostly cover the whole process pool so they reach the node search.
  function automatic request_t random_request();
    request_t          r;
    logic [MASK_W-1:0] busy;
    int                sel, k;
    sel = $urandom_range(0, 99);
    if (sel < 35)      r.cmd = CMD_ALLOC_IRQ;
    else if (sel < 55) r.cmd = CMD_REL_IRQ;
    else if (sel < 85) r.cmd = CMD_ALLOC_PROC;
    else               r.cmd = CMD_REL_PROC;
    case ($urandom_range(0, 9))
      0:       r.kind = KIND_OTHER;
      1, 2, 3: r.kind = KIND_SDMA;
      4, 5, 6: r.kind = KIND_RCV;
      default: r.kind = KIND_GENERAL;
    endcase
    r.ctrl       = 1'($urandom_range(0, 1));
    r.node_given = 1'($urandom_range(0, 1));
    r.req_node   = $urandom_range(0, 1) ? (pool_mask[POOL_PROC] & {$urandom(), $urandom()})
                                        : random_mask();
    if (r.cmd == CMD_ALLOC_PROC) begin
      case ($urandom_range(0, 9))
        0, 1:    r.allowed = 64'd1 << $urandom_range(0, 63);
        2:       r.allowed = sparse_mask(2, 4);
        3:       r.allowed = '1;
        default: r.allowed = pool_mask[POOL_PROC] | random_mask();
      endcase
    end else begin
      r.allowed = random_mask();
    end
    if (r.cmd == CMD_REL_PROC)     busy = busy_map[POOL_PROC];
    else if (r.kind == KIND_RCV)   busy = busy_map[POOL_RCV];
    else                           busy = busy_map[POOL_DFLT];
    r.rel = CPU_W'($urandom_range(0, 63));
    if (busy != '0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, $countones(busy) - 1);
      for (int i = 0; i < MASK_W; i++) begin
        if (busy[i]) begin
          if (k == 0) r.rel = CPU_W'(i);
          k--;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every command and kind, control context, preset and declined process
  // requests, node preference and the full-pool generation step.
  task automatic test_directed_cases();
    send_idle_max = 0;
    stall_max     = 0;
    configure_pools(64'h8000_0000_0000_0001, 64'h6, 64'hF0, 64'h30);
    send_request(build_request(CMD_ALLOC_IRQ, KIND_SDMA, 1'b0, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_IRQ, KIND_GENERAL, 1'b0, 6'd0, '0, '0, 1'b0));
    // default pool is now full: new generation, start over at the bottom
    send_request(build_request(CMD_ALLOC_IRQ, KIND_SDMA, 1'b1, 6'd63, '1, '1, 1'b1));
    send_request(build_request(CMD_ALLOC_IRQ, KIND_OTHER, 1'b0, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_IRQ, KIND_OTHER, 1'b1, 6'd63, '1, '1, 1'b1));
    send_request(build_request(CMD_ALLOC_IRQ, KIND_RCV, 1'b1, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_IRQ, KIND_RCV, 1'b0, 6'd0, '0, '0, 1'b0));
    // receive release with the control flag still hits the receive pool
    send_request(build_request(CMD_REL_IRQ, KIND_RCV, 1'b1, 6'd1, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_IRQ, KIND_RCV, 1'b0, 6'd1, '0, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0, '1, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0,
                               64'h8000_0000_0000_0000, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0, 64'h3, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0, '1, '0, 1'b1));
    send_request(build_request(CMD_ALLOC_PROC, KIND_GENERAL, 1'b0, 6'd0, '1, 64'hC0, 1'b1));
    send_request(build_request(CMD_REL_PROC, KIND_SDMA, 1'b0, 6'd63, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_PROC, KIND_SDMA, 1'b0, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_IRQ, KIND_GENERAL, 1'b0, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_IRQ, KIND_SDMA, 1'b0, 6'd63, '0, '0, 1'b0));
    drain_results();
  endtask

  // Empty candidate sets: empty interrupt pools and an empty process pool.
  task automatic test_empty_candidates();
    write_register(REG_DEFAULT_POOL, '0);
    write_register(REG_RCV_POOL, '0);
    send_request(build_request(CMD_ALLOC_IRQ, KIND_SDMA, 1'b0, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_IRQ, KIND_RCV, 1'b1, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_ALLOC_IRQ, KIND_RCV, 1'b0, 6'd0, '0, '0, 1'b0));
    drain_results();
    write_register(REG_PROC_POOL, '0);
    send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0, '1, '1, 1'b1));
    send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0, '0, '0, 1'b0));
    drain_results();
  endtask

  // Hold the result side off for a long stretch while words keep coming, so
  // the pipeline fills and in_tready has to drop.
  task automatic test_output_backpressure();
    configure_pools(64'hFF, 64'hFF00, 64'hFFFF_0000, 64'h00FF_0000);
    send_idle_max = 0;
    stall_max     = 0;
    hold_request  = 1'b1;
    repeat (40) send_request(random_request());
    drain_results();
  endtask

  task automatic apply_setting(input pool_setting_t setting);
    logic [63:0] proc;
    case (setting)
      SET_FULL:  configure_pools('1, '1, '1, '1);
      SET_EMPTY: configure_pools('0, '0, '0, '0);
      SET_HIGH: begin
        proc = 64'h8000_0000_0000_0000 | (sparse_mask(2, 6) << 48);
        configure_pools(64'h8000_0000_0000_0000 | (sparse_mask(1, 3) << 56),
                        sparse_mask(1, 4) << 40, proc, proc & {$urandom(), 32'd0});
      end
      default: begin
        proc = sparse_mask(3, 8);
        configure_pools(sparse_mask(1, 5), sparse_mask(1, 5), proc,
                        (proc & {$urandom(), $urandom()}) | sparse_mask(0, 2));
      end
    endcase
  endtask

  task automatic run_phase(input pool_setting_t setting, input int send_max,
                           input int recv_max, input int words);
    drain_results();
    apply_setting(setting);
    send_idle_max = send_max;
    stall_max     = recv_max;
    repeat (words) send_request(random_request());
  endtask

  // Random traffic under each pool setting, with and without idling.
  task automatic test_random_traffic();
    run_phase(SET_SPARSE, IDLE_MAX, IDLE_MAX, PHASE_WORDS);
    run_phase(SET_FULL,   0,        0,        PHASE_WORDS);
    run_phase(SET_SPARSE, IDLE_MAX, 0,        PHASE_WORDS);
    run_phase(SET_EMPTY,  0,        IDLE_MAX, PHASE_WORDS);
    run_phase(SET_HIGH,   IDLE_MAX, IDLE_MAX, PHASE_WORDS);
    run_phase(SET_SPARSE, IDLE_MAX, IDLE_MAX, PHASE_WORDS);
    drain_results();
  endtask

  // Empty pools raise their generation on every allocation; push all three
  // up, step them back with releases, then run traffic on top.
  task automatic test_generation_steps();
    apply_setting(SET_EMPTY);
    send_idle_max = 0;
    stall_max     = 0;
    repeat (GEN_WORDS)
      send_request(build_request(CMD_ALLOC_IRQ, KIND_SDMA, 1'b0, 6'd0, '0, '0, 1'b0));
    repeat (GEN_WORDS)
      send_request(build_request(CMD_ALLOC_IRQ, KIND_RCV, 1'b0, 6'd0, '0, '0, 1'b0));
    repeat (GEN_WORDS)
      send_request(build_request(CMD_ALLOC_PROC, KIND_SDMA, 1'b0, 6'd0, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_IRQ, KIND_GENERAL, 1'b0, 6'd5, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_IRQ, KIND_RCV, 1'b0, 6'd5, '0, '0, 1'b0));
    send_request(build_request(CMD_REL_PROC, KIND_SDMA, 1'b0, 6'd5, '0, '0, 1'b0));
    run_phase(SET_SPARSE, IDLE_MAX, IDLE_MAX, 200);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int p = 0; p < 3; p++) begin
      pool_mask[p] = '0;
      busy_map[p]  = '0;
      gen_count[p] = '0;
    end
    dev_node    = '0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wr_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_empty_candidates();
    test_output_backpressure();
    test_random_traffic();
    test_generation_steps();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_cpu_affinity_allocator passed");
    end else begin
      $display("tb_cpu_affinity_allocator failed");
    end
    $finish;
  end

endmodule
